// ===== rtl/vtv_pkg.sv =====
// Shared types, constants and helpers for the vertex transform / viewport map pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vtv_pkg;

    // field widths
    localparam int POS_W   = 16;                 // Q8.8 input coordinate
    localparam int MAT_W   = 16;                 // Q4.12 matrix entry
    localparam int ROW_W   = 4 * MAT_W;          // one matrix row
    localparam int VP_W    = 12;                 // viewport values
    localparam int SX_W    = 20;                 // Q16.4 screen coordinate
    localparam int DEPTH_W = 16;                 // Q2.14 depth
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // internal widths
    localparam int PROD_W = 2 * POS_W;           // one 16x16 product
    localparam int CLIP_W = 34;                  // clip value, Q.20
    localparam int NUM_W  = 49;                  // signed dividend
    localparam int QB     = 22;                  // quotient bits kept; larger saturates
    localparam int DD_W   = CLIP_W + 1;          // 2|d|
    localparam int REM_W  = DD_W + QB;           // partial remainder
    localparam int ACC_W  = 25;                  // final sum before saturation

    // pipeline depth: product, sum, clip prep, numerator, divider, output
    localparam int DIV_LAT = QB + 1;
    localparam int LAT     = 4 + DIV_LAT + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd7;

    // reset values: identity matrix, 800x600 viewport at the origin
    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
    localparam logic [VP_W-1:0]  WIDTH_RST  = 12'd800;
    localparam logic [VP_W-1:0]  HEIGHT_RST = 12'd600;

    // clip w of one (2^20) used when w is zero
    localparam logic signed [CLIP_W-1:0] ONE_CLIP = 34'sd1048576;

    typedef logic signed [CLIP_W-1:0] clip_t;

    function automatic logic [SX_W-1:0] sat_sx(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'((1 << (SX_W - 1)) - 1));
        lo = -hi - ACC_W'(signed'(1));
        if (v > hi) return hi[SX_W-1:0];
        else if (v < lo) return lo[SX_W-1:0];
        else return v[SX_W-1:0];
    endfunction

    function automatic logic [DEPTH_W-1:0] sat_depth(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'((1 << (DEPTH_W - 1)) - 1));
        lo = -hi - ACC_W'(signed'(1));
        if (v > hi) return hi[DEPTH_W-1:0];
        else if (v < lo) return lo[DEPTH_W-1:0];
        else return v[DEPTH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vertex_transform_viewport_map_unit.sv =====
// Top level: config registers, matrix stage, numerator stages, three dividers, output.
// Depends on vtv_pkg, vtv_mvp, vtv_div.
//
//   channel  | direction | handshake            | payload
//   s_       | in        | s_valid / s_ready    | s_pos_x, s_pos_y, s_pos_z
//   m_       | out       | m_valid / m_ready    | m_screen_x, m_screen_y, m_depth, m_w_was_zero
//   cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One vertex per cycle while the output is not held; stages are products, sums, clip prep,
// numerators, a divider entry stage, one divider stage per quotient bit, output register.
// Synchronous active-low reset clears stage valids and loads register defaults.
// The whole pipeline holds while the output word waits; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_viewport_map_unit (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        s_valid,
    output logic                                       s_ready,
    input  wire logic signed [vtv_pkg::POS_W-1:0]      s_pos_x,
    input  wire logic signed [vtv_pkg::POS_W-1:0]      s_pos_y,
    input  wire logic signed [vtv_pkg::POS_W-1:0]      s_pos_z,
    output logic                                       m_valid,
    input  wire                                        m_ready,
    output logic signed [vtv_pkg::SX_W-1:0]            m_screen_x,
    output logic signed [vtv_pkg::SX_W-1:0]            m_screen_y,
    output logic signed [vtv_pkg::DEPTH_W-1:0]         m_depth,
    output logic                                       m_w_was_zero,
    input  wire                                        cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [vtv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [vtv_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import vtv_pkg::*;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;
    logic [LAT-1:3] wz_reg;

    logic [ROW_W-1:0] row0_reg, row1_reg, row2_reg, row3_reg;
    logic [VP_W-1:0]  left_reg, top_reg, width_reg, height_reg;

    clip_t cx, cy, cz, cw;
    clip_t sa_reg, sb_reg, sz_reg, d_reg, d4_reg;
    logic  wz3_reg;
    logic  wz_now;
    clip_t d_now;
    logic signed [NUM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [MAT_W-1:0] w8, h8;

    logic [QB-1:0] qx, qy, qz;
    logic          nxg, nyg, nzg;
    logic signed [ACC_W-1:0] ax, ay, az;

    logic [SX_W-1:0]    sx_reg, sy_reg;
    logic [DEPTH_W-1:0] dz_reg;

    assign en        = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg   <= ROW0_RST;
            row1_reg   <= ROW1_RST;
            row2_reg   <= ROW2_RST;
            row3_reg   <= ROW3_RST;
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROW0:   row0_reg   <= cfg_data;
                REG_ROW1:   row1_reg   <= cfg_data;
                REG_ROW2:   row2_reg   <= cfg_data;
                REG_ROW3:   row3_reg   <= cfg_data;
                REG_LEFT:   left_reg   <= cfg_data[VP_W-1:0];
                REG_TOP:    top_reg    <= cfg_data[VP_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[VP_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[VP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and the zero-w flag travel together
    assign vld_next = {vld_reg[LAT-2:0], s_valid};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // zero-w flag joins at the numerator stage
    always_ff @(posedge aclk) begin
        if (en) begin
            wz_reg <= {wz_reg[LAT-2:3], wz3_reg};
        end
    end

    vtv_mvp u_mvp (
        .aclk   (aclk),
        .en     (en),
        .pos_x  (s_pos_x),
        .pos_y  (s_pos_y),
        .pos_z  (s_pos_z),
        .row0   (row0_reg),
        .row1   (row1_reg),
        .row2   (row2_reg),
        .row3   (row3_reg),
        .clip_x (cx),
        .clip_y (cy),
        .clip_z (cz),
        .clip_w (cw)
    );

    // clip prep: divisor select and the offset sums cx + d and d - cy
    assign wz_now = (cw == '0);
    assign d_now  = wz_now ? ONE_CLIP : cw;
    always_ff @(posedge aclk) begin
        if (en) begin
            wz3_reg <= wz_now;
            d_reg   <= d_now;
            sa_reg  <= cx + d_now;
            sb_reg  <= d_now - cy;
            sz_reg  <= cz;
        end
    end

    // numerators: 8*W*(cx+d), 8*H*(d-cy), cz*16384
    assign w8 = signed'({1'b0, width_reg, 3'b000});
    assign h8 = signed'({1'b0, height_reg, 3'b000});
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= NUM_W'(sa_reg) * NUM_W'(w8);
            ny_reg <= NUM_W'(sb_reg) * NUM_W'(h8);
            nz_reg <= NUM_W'(sz_reg) <<< 14;
            d4_reg <= d_reg;
        end
    end

    vtv_div u_div_x (.aclk(aclk), .en(en), .num(nx_reg), .den(d4_reg),
                     .q_mag(qx), .q_neg(nxg));
    vtv_div u_div_y (.aclk(aclk), .en(en), .num(ny_reg), .den(d4_reg),
                     .q_mag(qy), .q_neg(nyg));
    vtv_div u_div_z (.aclk(aclk), .en(en), .num(nz_reg), .den(d4_reg),
                     .q_mag(qz), .q_neg(nzg));

    // signed quotient, origin offset, saturation
    always_comb begin
        ax = ACC_W'({left_reg, 4'b0000})
           + (nxg ? -ACC_W'(signed'({1'b0, qx})) : ACC_W'(signed'({1'b0, qx})));
        ay = ACC_W'({top_reg, 4'b0000})
           + (nyg ? -ACC_W'(signed'({1'b0, qy})) : ACC_W'(signed'({1'b0, qy})));
        az = nzg ? -ACC_W'(signed'({1'b0, qz})) : ACC_W'(signed'({1'b0, qz}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= sat_sx(ax);
            sy_reg <= sat_sx(ay);
            dz_reg <= sat_depth(az);
        end
    end

    assign m_valid      = vld_reg[LAT-1];
    assign m_screen_x   = signed'(sx_reg);
    assign m_screen_y   = signed'(sy_reg);
    assign m_depth      = signed'(dz_reg);
    assign m_w_was_zero = wz_reg[LAT-1];

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("stage valids moved during a stall");
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> vld_reg[LAT-1:1] == $past(vld_reg[LAT-2:0]))
        else $error("stage valids did not advance together");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word missing from first stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/vtv_mvp.sv =====
// Matrix-vector stage: 12 products registered, then four clip sums registered.
// Depends on vtv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtv_mvp (
    input  wire                                   aclk,
    input  wire                                   en,
    input  wire logic signed [vtv_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [vtv_pkg::POS_W-1:0] pos_y,
    input  wire logic signed [vtv_pkg::POS_W-1:0] pos_z,
    input  wire logic [vtv_pkg::ROW_W-1:0]        row0,
    input  wire logic [vtv_pkg::ROW_W-1:0]        row1,
    input  wire logic [vtv_pkg::ROW_W-1:0]        row2,
    input  wire logic [vtv_pkg::ROW_W-1:0]        row3,
    output vtv_pkg::clip_t                        clip_x,
    output vtv_pkg::clip_t                        clip_y,
    output vtv_pkg::clip_t                        clip_z,
    output vtv_pkg::clip_t                        clip_w
);
    import vtv_pkg::*;

    logic [ROW_W-1:0]         rows [4];
    logic signed [POS_W-1:0]  pos [3];
    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [MAT_W-1:0]  tr_reg [4];
    clip_t                    clip_reg [4];

    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;
    assign rows[3] = row3;
    assign pos[0]  = pos_x;
    assign pos[1]  = pos_y;
    assign pos[2]  = pos_z;

    // one multiplier per matrix entry, translation column needs none
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r][k] <= signed'(rows[r][MAT_W*k +: MAT_W]) * pos[k];
                end
                tr_reg[r] <= signed'(rows[r][MAT_W*3 +: MAT_W]);
            end
        end
    end

    // row sums, translation scaled by 256 for w = 1 in Q8.8
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2]) + (CLIP_W'(tr_reg[r]) <<< 8);
            end
        end
    end

    assign clip_x = clip_reg[0];
    assign clip_y = clip_reg[1];
    assign clip_z = clip_reg[2];
    assign clip_w = clip_reg[3];

endmodule

`default_nettype wire

// ===== rtl/vtv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounds half away from zero.
// Quotient magnitudes of 2^22 and above come out as all ones. Depends on vtv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtv_div (
    input  wire                                   aclk,
    input  wire                                   en,
    input  wire logic signed [vtv_pkg::NUM_W-1:0] num,
    input  wire logic signed [vtv_pkg::CLIP_W-1:0] den,
    output logic [vtv_pkg::QB-1:0]                q_mag,
    output logic                                  q_neg
);
    import vtv_pkg::*;

    logic [NUM_W-1:0]  an;
    logic [CLIP_W-1:0] ad;
    logic [REM_W-1:0]  nn;
    logic [DD_W-1:0]   dd;

    logic [REM_W-1:0]  rem_reg [QB+1];
    logic [DD_W-1:0]   dd_reg  [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic              neg_reg [QB+1];
    logic              ovf_reg [QB+1];

    // magnitudes; dividend 2|n|+|d| over 2|d| gives the rounded quotient
    always_comb begin
        an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ad = den[CLIP_W-1] ? CLIP_W'(-den) : CLIP_W'(den);
        nn = (REM_W'(an) << 1) + REM_W'(ad);
        dd = {ad, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= nn;
            dd_reg[0]  <= dd;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[CLIP_W-1];
            ovf_reg[0] <= nn >= {dd, {QB{1'b0}}};
        end
    end

    // bit stages, most significant quotient bit first
    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic [REM_W-1:0] sh;
        logic             ge;
        assign sh = {dd_reg[k], {QB{1'b0}}} >> (k + 1);
        assign ge = rem_reg[k] >= sh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rem_reg[k] - sh : rem_reg[k];
                dd_reg[k+1]  <= dd_reg[k];
                q_reg[k+1]   <= q_reg[k] | (QB'(ge) << (QB - 1 - k));
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign q_mag = ovf_reg[QB] ? '1 : q_reg[QB];
    assign q_neg = neg_reg[QB];

endmodule

`default_nettype wire
